/* rtl/ptts_pkg.sv */
// Shared types and codes for the periodic task table scheduler.
// No dependencies; used by ptts_cell, ptts_head and the top level.
package ptts_pkg;

  localparam int ID_W    = 8;
  localparam int HND_W   = 16;
  localparam int CNT16_W = 16;
  localparam int SLOT_W  = 3;
  localparam int TS_W    = 2;
  localparam int FN_W    = 3;

  // Most results one dispatch may emit, and the width of its counter.
  localparam int MAX_RES = 8;
  localparam int RES_CNT_W = 4;

  localparam logic [FN_W-1:0] FN_TICK     = 3'd0;
  localparam logic [FN_W-1:0] FN_ADD      = 3'd1;
  localparam logic [FN_W-1:0] FN_DELETE   = 3'd2;
  localparam logic [FN_W-1:0] FN_QUERY    = 3'd3;
  localparam logic [FN_W-1:0] FN_DISPATCH = 3'd4;

  localparam logic [TS_W-1:0] TS_STOPPED   = 2'd0;
  localparam logic [TS_W-1:0] TS_RUNNABLE  = 2'd1;
  localparam logic [TS_W-1:0] TS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic               runnable;
    logic [ID_W-1:0]    id;
    logic [HND_W-1:0]   handle;
    logic [CNT16_W-1:0] countdown;
    logic [CNT16_W-1:0] period;
  } slot_t;

  typedef struct packed {
    logic [FN_W-1:0]    func;
    logic [ID_W-1:0]    id;
    logic [HND_W-1:0]   handle;
    logic [CNT16_W-1:0] period;
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [HND_W-1:0]  handle;
    logic [TS_W-1:0]   tstate;
    logic              done;
    logic [SLOT_W-1:0] slot;
  } res_t;

  typedef struct packed {
    logic claim;  // first matching / free slot for add, delete, query
    logic due;    // dispatch entry taken from this slot
  } hit_t;

endpackage

/* rtl/ptts_cell.sv */
// One table slot of the scheduler chain; loads its neighbor's record on shift.
// Depends on ptts_pkg.
module ptts_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  ptts_pkg::slot_t d,
  output ptts_pkg::slot_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

/* rtl/ptts_head.sv */
// Head cell logic: applies the current operation to the slot at the chain head.
// Depends on ptts_pkg.
module ptts_head (
  input  ptts_pkg::op_t                  op,
  input  logic                           found,
  input  logic                           room,
  input  logic [ptts_pkg::SLOT_W-1:0]    slot,
  input  ptts_pkg::slot_t                rec,
  output ptts_pkg::slot_t                rec_next,
  output ptts_pkg::hit_t                 hit,
  output ptts_pkg::res_t                 res
);

  logic id_match;

  assign id_match = (rec.id == op.id);

  always_comb begin
    rec_next = rec;
    hit      = '0;
    res      = '0;
    case (op.func)
      ptts_pkg::FN_TICK: begin
        if (rec.runnable && rec.countdown != '0) begin
          rec_next.countdown = rec.countdown - 16'd1;
        end
      end
      ptts_pkg::FN_ADD: begin
        if (!found && !rec.runnable) begin
          rec_next.runnable  = 1'b1;
          rec_next.id        = op.id;
          rec_next.handle    = op.handle;
          rec_next.countdown = op.period;
          rec_next.period    = op.period;
          hit.claim  = 1'b1;
          res.id     = op.id;
          res.tstate = ptts_pkg::TS_STOPPED;
          res.done   = 1'b1;
          res.slot   = slot;
        end
      end
      ptts_pkg::FN_DELETE: begin
        if (!found && id_match) begin
          rec_next.runnable = 1'b0;
          hit.claim  = 1'b1;
          res.id     = op.id;
          res.tstate = ptts_pkg::TS_STOPPED;
          res.done   = 1'b1;
          res.slot   = slot;
        end
      end
      ptts_pkg::FN_QUERY: begin
        if (!found && id_match) begin
          hit.claim  = 1'b1;
          res.id     = op.id;
          res.tstate = rec.runnable ? ptts_pkg::TS_RUNNABLE : ptts_pkg::TS_STOPPED;
          res.done   = 1'b1;
          res.slot   = slot;
        end
      end
      ptts_pkg::FN_DISPATCH: begin
        if (room && rec.runnable && rec.countdown == '0) begin
          rec_next.countdown = rec.period;
          hit.due    = 1'b1;
          res.id     = rec.id;
          res.handle = rec.handle;
          res.tstate = ptts_pkg::TS_RUNNABLE;
          res.done   = 1'b1;
          res.slot   = slot;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/periodic_task_table_scheduler.sv */
// Periodic task table scheduler: NUM_SLOTS task slots held in a ring of cells.
// An accepted item rotates the whole table once through the head cell, one
// slot per cycle while the output is free to take a result. The next item is
// taken only after a load step, NUM_SLOTS scan steps and one closing step.
// Dispatch results leave in slot order; the final result of every item
// carries last and leaves in the closing step. Reset clears the table to
// stopped slots with id 0. Depends on ptts_pkg, ptts_cell, ptts_head.
module periodic_task_table_scheduler #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  task_id,
  input  logic [15:0] task_handle,
  input  logic [15:0] period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_id,
  output logic [15:0] out_handle,
  output logic [1:0]  task_state,
  output logic        done_res,
  output logic [2:0]  slot_index,
  output logic        last
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t                            state;
  ptts_pkg::op_t                     op;
  logic [IDX_W-1:0]                  idx;
  logic                              found;
  logic [ptts_pkg::RES_CNT_W-1:0]    disp_cnt;
  ptts_pkg::res_t                    pend;
  ptts_pkg::res_t                    init_res;
  ptts_pkg::slot_t                   chain_q [NUM_SLOTS];
  ptts_pkg::slot_t                   chain_d [NUM_SLOTS];
  ptts_pkg::slot_t                   head_rec;
  ptts_pkg::hit_t                    hit;
  ptts_pkg::res_t                    head_res;
  logic                              out_free;
  logic                              shift;
  logic                              emit;
  logic                              room;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign shift    = (state == ST_SCAN) && out_free;
  assign room     = (disp_cnt < ptts_pkg::RES_CNT_W'(ptts_pkg::MAX_RES));
  assign emit     = ((state == ST_FINISH) && out_free) ||
                    (shift && hit.due && disp_cnt != '0);

  always_comb begin
    init_res = '0;
    case (func)
      ptts_pkg::FN_ADD, ptts_pkg::FN_DELETE: begin
        init_res.id = task_id;
      end
      ptts_pkg::FN_QUERY: begin
        init_res.id     = task_id;
        init_res.tstate = ptts_pkg::TS_NOT_FOUND;
      end
      default: ;
    endcase
  end

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    if (k == NUM_SLOTS - 1) begin : g_tail
      assign chain_d[k] = head_rec;
    end else begin : g_link
      assign chain_d[k] = chain_q[k+1];
    end
    ptts_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (chain_d[k]),
      .q     (chain_q[k])
    );
  end

  ptts_head u_head (
    .op       (op),
    .found    (found),
    .room     (room),
    .slot     (3'(idx)),
    .rec      (chain_q[0]),
    .rec_next (head_rec),
    .hit      (hit),
    .res      (head_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      found     <= 1'b0;
      disp_cnt  <= '0;
      idx       <= '0;
    end else begin
      if (out_valid && out_ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op.func   <= func;
            op.id     <= task_id;
            op.handle <= task_handle;
            op.period <= period;
            pend      <= init_res;
            idx       <= '0;
            found     <= 1'b0;
            disp_cnt  <= '0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (out_free) begin
            if (hit.claim) begin
              found <= 1'b1;
              pend  <= head_res;
            end
            if (hit.due) begin
              if (disp_cnt != '0) begin
                out_valid  <= 1'b1;
                out_id     <= pend.id;
                out_handle <= pend.handle;
                task_state <= pend.tstate;
                done_res   <= pend.done;
                slot_index <= pend.slot;
                last       <= 1'b0;
              end
              pend     <= head_res;
              disp_cnt <= disp_cnt + 1'b1;
            end
            if (idx == IDX_LAST) begin
              state <= ST_FINISH;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_id     <= pend.id;
            out_handle <= pend.handle;
            task_state <= pend.tstate;
            done_res   <= pend.done;
            slot_index <= pend.slot;
            last       <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_table_holds: assert property (@(posedge clk) disable iff (rst)
    (state != ST_SCAN) |=> $stable(chain_q[0]))
    else $error("table moved outside a scan");

  a_accept_scans: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SCAN && idx == '0))
    else $error("accepted item did not start a scan");

  a_dispatch_cap: assert property (@(posedge clk) disable iff (rst)
    disp_cnt <= ptts_pkg::RES_CNT_W'(ptts_pkg::MAX_RES))
    else $error("dispatch result count above limit");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result issued over an untaken result");

endmodule
